[src/lbbr_pkg.sv]
// ----------------------------------------------------------------------------
// lbbr_pkg
// Shared types and constants for the lane border break repair block.
// ----------------------------------------------------------------------------
`default_nettype none
package lbbr_pkg;
    localparam logic [1:0] ACT_LOAD   = 2'd0;
    localparam logic [1:0] ACT_DETECT = 2'd1;
    localparam logic [1:0] ACT_READ   = 2'd2;

    localparam logic [1:0] REG_COLUMN_MIN = 2'd0;
    localparam logic [1:0] REG_COLUMN_MAX = 2'd1;
    localparam logic [1:0] REG_JUMP_LIMIT = 2'd2;
    localparam logic [1:0] REG_LOST_RUN   = 2'd3;

    localparam int EDGE_MARGIN = 2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_READ,
        ST_SCAN_L,
        ST_SCAN_R,
        ST_FILL_SETUP,
        ST_FILL_DIV,
        ST_FILL_WR,
        ST_OUT
    } state_t;

    // Division request and response between the sequencer and the divider.
    typedef struct packed {
        logic        start;
        logic        neg;
        logic [15:0] num;
        logic [7:0]  den;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic [16:0] quo;
    } div_rsp_t;
endpackage
`default_nettype wire

[src/lbbr_ram.sv]
// ----------------------------------------------------------------------------
// lbbr_ram
// Generic single-port synchronous RAM with a registered read.
// ----------------------------------------------------------------------------
`default_nettype none
module lbbr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 120
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule
`default_nettype wire

[src/lbbr_div.sv]
// ----------------------------------------------------------------------------
// lbbr_div
// Restoring divider, one quotient bit per cycle, 16-bit magnitude by 8 bits.
// A negative quotient is rounded toward minus infinity.
// ----------------------------------------------------------------------------
`default_nettype none
module lbbr_div
    import lbbr_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire div_req_t req,
    output div_rsp_t      rsp
);
    logic        busy_reg;
    logic [4:0]  cnt_reg;
    logic [15:0] q_reg;
    logic [8:0]  r_reg;
    logic        neg_reg;
    logic [7:0]  den_reg;
    logic        done_reg;
    logic [8:0]  trial;
    logic        rem_nz;

    assign trial  = {r_reg[7:0], q_reg[15]};
    assign rem_nz = (r_reg != 9'd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 5'd16;
                q_reg    <= req.num;
                r_reg    <= '0;
                neg_reg  <= req.neg;
                den_reg  <= req.den;
            end
            else if (busy_reg)
            begin
                if (trial >= {1'b0, den_reg})
                begin
                    r_reg <= trial - {1'b0, den_reg};
                    q_reg <= {q_reg[14:0], 1'b1};
                end
                else
                begin
                    r_reg <= trial;
                    q_reg <= {q_reg[14:0], 1'b0};
                end
                cnt_reg <= cnt_reg - 5'd1;
                if (cnt_reg == 5'd1)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quo  = neg_reg ? (17'd0 - {1'b0, q_reg} - {16'd0, rem_nz}) : {1'b0, q_reg};
endmodule
`default_nettype wire

[src/lane_border_break_repair.sv]
// ----------------------------------------------------------------------------
// lane_border_break_repair
// Per-row lane border store with break detection and straight-line repair.
// ----------------------------------------------------------------------------
// The block holds a left and a right border column for each image row in two
// single-port RAMs. Loads and reads each answer through the output register,
// a read after the registered RAM read. A detect walks each side one row per
// cycle, and when both sides break it rewrites each row between the break
// points using a bit-serial divider. Stored rows are undefined until loaded.
// ----------------------------------------------------------------------------
`default_nettype none
module lane_border_break_repair
    import lbbr_pkg::*;
#(
    parameter int IMAGE_H = 120
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // tdata: action[1:0], row[8:2], left_col[16:9], right_col[24:17]
    input  wire logic [31:0] s_tdata,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // tdata: found[0], a_col[8:1], a_row[15:9], b_col[23:16], b_row[30:24],
    // c_col[38:31], c_row[45:39], d_col[53:46], d_row[60:54],
    // read_left[68:61], read_right[76:69]
    output logic [79:0]      m_tdata,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [7:0]  cfg_data
);
    localparam int AW = $clog2(IMAGE_H);
    localparam int RW = (AW > 7) ? AW : 7;
    localparam logic [RW-1:0] ROW_TOP = RW'(IMAGE_H - 2);
    localparam logic [RW-1:0] ROW_BOT = RW'(IMAGE_H / 4);
    localparam logic [RW-1:0] ROW_END = RW'(IMAGE_H - 1);

    logic [7:0] cmin_reg, cmax_reg, jlim_reg;
    logic [6:0] lrun_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmin_reg <= 8'd0;
            cmax_reg <= 8'd187;
            jlim_reg <= 8'd12;
            lrun_reg <= 7'd3;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_COLUMN_MIN: cmin_reg <= cfg_data;
                REG_COLUMN_MAX: cmax_reg <= cfg_data;
                REG_JUMP_LIMIT: jlim_reg <= cfg_data;
                REG_LOST_RUN:   lrun_reg <= cfg_data[6:0];
                default:        ;
            endcase
        end
    end

    state_t state_reg, state_next;

    logic [1:0]    act;
    logic [6:0]    in_row;
    assign act    = s_tdata[1:0];
    assign in_row = s_tdata[8:2];

    // Memory ports.
    logic          l_we, r_we;
    logic [AW-1:0] addr;
    logic [7:0]    l_wd, r_wd, l_rd, r_rd;

    lbbr_ram #(.WIDTH(8), .DEPTH(IMAGE_H)) u_left (
        .clk(clk), .we(l_we), .addr(addr), .wdata(l_wd), .rdata(l_rd));
    lbbr_ram #(.WIDTH(8), .DEPTH(IMAGE_H)) u_right (
        .clk(clk), .we(r_we), .addr(addr), .wdata(r_wd), .rdata(r_rd));

    // Scan state: y_reg is the row addressed this cycle, rd_v_reg marks a row
    // whose data arrives this cycle at row rd_y_reg.
    logic [RW-1:0] y_reg, rd_y_reg;
    logic          rd_v_reg;
    logic          have_last_reg, have_lo_reg, side_found_reg;
    logic [7:0]    last_x_reg;
    logic [RW-1:0] last_y_reg;
    logic [7:0]    lost_reg;
    logic [7:0]    lo_col_reg, hi_col_reg;
    logic [RW-1:0] lo_row_reg, hi_row_reg;
    logic [7:0]    a_col_reg, b_col_reg;
    logic [RW-1:0] a_row_reg, b_row_reg;
    logic          fill_right_reg;
    logic [RW-1:0] fy_reg, fye_reg;
    logic [7:0]    fx_reg;
    logic [79:0]   out_reg;
    logic          out_v_reg;
    logic [7:0]    rd_l_reg, rd_r_reg;
    logic          rd_ok_reg;

    // Point evaluation for the row whose data is present.
    logic [7:0] cur_x;
    logic       cur_v;
    logic [8:0] diff;
    logic       jump;
    assign cur_x = (state_reg == ST_SCAN_R) ? r_rd : l_rd;
    always_comb
    begin
        if (state_reg == ST_SCAN_R)
            cur_v = {1'b0, cur_x} + 9'd2 < {1'b0, cmax_reg};
        else
            cur_v = {1'b0, cur_x} > {1'b0, cmin_reg} + 9'd2;
    end
    assign diff = (cur_x >= last_x_reg) ? {1'b0, cur_x - last_x_reg}
                                        : {1'b0, last_x_reg - cur_x};
    assign jump = diff > {1'b0, jlim_reg};

    // Line fill arithmetic: x = x1 + (x2-x1)*(y-y1)/(y2-y1), rounded toward minus infinity.
    logic signed [9:0]  dx;
    logic signed [RW+1:0] dy_full, ddy;
    logic signed [19:0] prod;
    logic               prod_neg;
    logic [15:0]        prod_mag;
    logic [7:0]         den_mag;
    div_req_t           dreq;
    div_rsp_t           drsp;

    assign dx      = $signed({2'b00, hi_col_reg}) - $signed({2'b00, lo_col_reg});
    assign dy_full = $signed({2'b00, hi_row_reg}) - $signed({2'b00, lo_row_reg});
    assign ddy     = $signed({2'b00, fy_reg}) - $signed({2'b00, lo_row_reg});
    assign prod     = 20'(dx) * 20'(ddy);
    assign prod_neg = prod[19] ^ dy_full[RW+1];
    assign prod_mag = prod[19] ? 16'(-prod) : prod[15:0];
    assign den_mag  = dy_full[RW+1] ? 8'(-dy_full) : dy_full[7:0];

    lbbr_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

    logic signed [17:0] fsum;
    logic [7:0]         fclamp;
    assign fsum = $signed({10'd0, lo_col_reg}) + $signed({drsp.quo[16], drsp.quo});
    always_comb
    begin
        if (fsum < $signed({10'd0, cmin_reg}))
            fclamp = cmin_reg;
        else
            fclamp = fsum[7:0];
        if (fsum > $signed({10'd0, cmax_reg}) || fclamp > cmax_reg)
            fclamp = cmax_reg;
    end

    assign s_tready = (state_reg == ST_IDLE) && !out_v_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    logic scan_hit, scan_done;
    always_comb
    begin
        scan_hit = 1'b0;
        if (rd_v_reg)
        begin
            if (!have_lo_reg)
                scan_hit = cur_v && have_last_reg && jump;
            else
                scan_hit = cur_v;
        end
        scan_done = scan_hit || (rd_v_reg && rd_y_reg == ROW_BOT);
    end

    always_comb
    begin
        state_next = state_reg;
        l_we = 1'b0;
        r_we = 1'b0;
        l_wd = fx_reg;
        r_wd = fx_reg;
        addr = y_reg[AW-1:0];
        dreq = '0;
        dreq.num = prod_mag;
        dreq.den = den_mag;
        dreq.neg = prod_neg;
        case (state_reg)
            ST_IDLE:
            begin
                // A detect starts its walk at the top scan row right away.
                addr = (act == ACT_DETECT) ? ROW_TOP[AW-1:0] : AW'(in_row);
                l_wd = s_tdata[16:9];
                r_wd = s_tdata[24:17];
                if (s_tvalid && s_tready)
                begin
                    case (act)
                        ACT_LOAD:
                        begin
                            if (int'(in_row) < IMAGE_H)
                            begin
                                l_we = 1'b1;
                                r_we = 1'b1;
                            end
                            state_next = ST_OUT;
                        end
                        ACT_READ:   state_next = ST_READ;
                        ACT_DETECT: state_next = ST_SCAN_L;
                        default:    state_next = ST_OUT;
                    endcase
                end
            end
            ST_READ:   state_next = ST_OUT;
            ST_SCAN_L:
            begin
                if (scan_done)
                begin
                    // The right side walk restarts at the top scan row.
                    addr = ROW_TOP[AW-1:0];
                    state_next = ST_SCAN_R;
                end
            end
            ST_SCAN_R:
            begin
                if (scan_done)
                begin
                    if (side_found_reg && scan_hit)
                        state_next = ST_FILL_SETUP;
                    else
                        state_next = ST_OUT;
                end
            end
            ST_FILL_SETUP:
            begin
                if (fy_reg > fye_reg || dy_full == '0)
                begin
                    state_next = fill_right_reg ? ST_OUT : ST_FILL_SETUP;
                end
                else
                begin
                    dreq.start = 1'b1;
                    state_next = ST_FILL_DIV;
                end
            end
            ST_FILL_DIV: if (drsp.done) state_next = ST_FILL_WR;
            ST_FILL_WR:
            begin
                addr = fy_reg[AW-1:0];
                l_we = !fill_right_reg;
                r_we = fill_right_reg;
                state_next = ST_FILL_SETUP;
            end
            ST_OUT:    if (!out_v_reg) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // Datapath registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg <= 1'b0;
            rd_v_reg  <= 1'b0;
        end
        else
        begin
            if (out_v_reg && m_tready)
                out_v_reg <= 1'b0;
            case (state_reg)
                ST_IDLE:
                begin
                    rd_ok_reg <= int'(in_row) < IMAGE_H;
                    y_reg     <= ROW_TOP;
                    rd_v_reg  <= 1'b0;
                    have_last_reg  <= 1'b0;
                    have_lo_reg    <= 1'b0;
                    side_found_reg <= 1'b0;
                    lost_reg       <= '0;
                    fill_right_reg <= 1'b0;
                    // The result register holds the waiting beat until a new
                    // input beat is taken.
                    if (s_tvalid && s_tready)
                        out_reg <= '0;
                    if (s_tvalid && s_tready && act == ACT_DETECT)
                    begin
                        y_reg    <= ROW_TOP - RW'(1);
                        rd_v_reg <= 1'b1;
                        rd_y_reg <= ROW_TOP;
                    end
                end
                ST_READ:
                begin
                    if (rd_ok_reg)
                    begin
                        out_reg[68:61] <= l_rd;
                        out_reg[76:69] <= r_rd;
                    end
                end
                ST_SCAN_L, ST_SCAN_R:
                begin
                    rd_v_reg <= (y_reg >= ROW_BOT) && !scan_done;
                    rd_y_reg <= y_reg;
                    y_reg    <= y_reg - RW'(1);
                    if (rd_v_reg && !have_lo_reg)
                    begin
                        if (cur_v)
                        begin
                            if (have_last_reg && jump)
                            begin
                                lo_col_reg <= last_x_reg;
                                lo_row_reg <= last_y_reg;
                            end
                            hi_col_reg    <= cur_x;
                            hi_row_reg    <= rd_y_reg;
                            last_x_reg    <= cur_x;
                            last_y_reg    <= rd_y_reg;
                            have_last_reg <= 1'b1;
                            lost_reg      <= '0;
                        end
                        else if (have_last_reg)
                        begin
                            lost_reg <= lost_reg + 8'd1;
                            if (lost_reg + 8'd1 >= {1'b0, lrun_reg})
                            begin
                                lo_col_reg  <= last_x_reg;
                                lo_row_reg  <= last_y_reg;
                                have_lo_reg <= 1'b1;
                            end
                        end
                    end
                    else if (rd_v_reg && cur_v)
                    begin
                        hi_col_reg <= cur_x;
                        hi_row_reg <= rd_y_reg;
                    end
                    if (scan_done && state_reg == ST_SCAN_L)
                    begin
                        side_found_reg <= scan_hit;
                        a_col_reg <= have_lo_reg ? lo_col_reg : last_x_reg;
                        a_row_reg <= have_lo_reg ? lo_row_reg : last_y_reg;
                        b_col_reg <= cur_x;
                        b_row_reg <= rd_y_reg;
                        y_reg     <= ROW_TOP - RW'(1);
                        rd_v_reg  <= 1'b1;
                        rd_y_reg  <= ROW_TOP;
                        have_last_reg <= 1'b0;
                        have_lo_reg   <= 1'b0;
                        lost_reg      <= '0;
                    end
                    if (scan_done && state_reg == ST_SCAN_R)
                    begin
                        rd_v_reg <= 1'b0;
                        if (side_found_reg && scan_hit)
                        begin
                            out_reg[0]     <= 1'b1;
                            out_reg[8:1]   <= a_col_reg;
                            out_reg[15:9]  <= a_row_reg[6:0];
                            out_reg[23:16] <= b_col_reg;
                            out_reg[30:24] <= b_row_reg[6:0];
                            out_reg[38:31] <= have_lo_reg ? lo_col_reg : last_x_reg;
                            out_reg[45:39] <= have_lo_reg ? lo_row_reg[6:0]
                                                          : last_y_reg[6:0];
                            out_reg[53:46] <= cur_x;
                            out_reg[60:54] <= rd_y_reg[6:0];
                            // Left pair goes first into the fill registers;
                            // the right pair waits in the output register.
                            lo_col_reg <= a_col_reg;
                            lo_row_reg <= a_row_reg;
                            hi_col_reg <= b_col_reg;
                            hi_row_reg <= b_row_reg;
                            fy_reg  <= b_row_reg;
                            fye_reg <= (a_row_reg > ROW_END) ? ROW_END : a_row_reg;
                        end
                    end
                end
                ST_FILL_SETUP:
                begin
                    if (fy_reg > fye_reg || dy_full == '0)
                    begin
                        if (!fill_right_reg)
                        begin
                            fill_right_reg <= 1'b1;
                            lo_col_reg <= out_reg[38:31];
                            lo_row_reg <= RW'(out_reg[45:39]);
                            hi_col_reg <= out_reg[53:46];
                            hi_row_reg <= RW'(out_reg[60:54]);
                            fy_reg     <= RW'(out_reg[60:54]);
                            fye_reg    <= (RW'(out_reg[45:39]) > ROW_END) ? ROW_END
                                                                 : RW'(out_reg[45:39]);
                        end
                    end
                end
                ST_FILL_DIV: if (drsp.done) fx_reg <= fclamp;
                ST_FILL_WR:  fy_reg <= fy_reg + RW'(1);
                ST_OUT:
                begin
                    if (!out_v_reg)
                        out_v_reg <= 1'b1;
                end
                default: ;
            endcase
        end
    end

    assign m_tvalid = out_v_reg;
    assign m_tdata  = out_reg;
endmodule
`default_nettype wire
